FILE: rtl/ethercat_datagram_parser_defines.svh
// ----------------------------------------------------------------------------
// ethercat_datagram_parser_defines
// Assertion macros shared by the parser checkers.
// ----------------------------------------------------------------------------
`ifndef ETHERCAT_DATAGRAM_PARSER_DEFINES_SVH
`define ETHERCAT_DATAGRAM_PARSER_DEFINES_SVH

// check a property outside of reset
`define EDP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define EDP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/edp_pkg.sv
// ----------------------------------------------------------------------------
// edp_pkg
// Types and constants of the EtherCAT datagram parser.
// ----------------------------------------------------------------------------
`default_nettype none

package edp_pkg;

  localparam int unsigned FRAME_HDR_BYTES = 2;
  localparam int unsigned DG_HDR_BYTES    = 10;
  localparam int unsigned LEN_W           = 11;
  localparam int unsigned FOLLOW_BIT      = 15;

  localparam int unsigned EV_DEPTH = 4;
  localparam int unsigned EV_PTR_W = $clog2(EV_DEPTH);
  localparam int unsigned EV_CNT_W = $clog2(EV_DEPTH + 1);

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DGRAM = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] STAT_CLEAN      = 2'd0;
  localparam logic [1:0] STAT_SHORT      = 2'd1;
  localparam logic [1:0] STAT_UNFINISHED = 2'd2;

  typedef enum logic [2:0] {
    PH_FRAME  = 3'd0,
    PH_HDR    = 3'd1,
    PH_DATA   = 3'd2,
    PH_WKC    = 3'd3,
    PH_IGNORE = 3'd4
  } phase_t;

  // one accepted byte's worth of results
  typedef struct packed {
    logic             has_main;
    logic             main_dgram;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] data_offset;
    logic [7:0]       cmd;
    logic [7:0]       tag;
    logic [31:0]      addr;
    logic [LEN_W-1:0] len;
    logic [15:0]      wkc;
    logic             has_end;
    logic [7:0]       total;
    logic [1:0]       status;
  } ev_t;

endpackage

`default_nettype wire

FILE: rtl/ethercat_datagram_parser.sv
// ----------------------------------------------------------------------------
// ethercat_datagram_parser
// EtherCAT frame payload parser. Bytes go in through a push/full port with a
// frame_end flag on the last byte of a frame. Results come out through an
// empty/pop port, one result per beat: data bytes with their offset, a
// datagram record after each working counter, and a report at frame end with
// the datagram count and status; run_last marks the last result of a byte.
// A byte is taken every cycle while full is low. Its results pass through
// the event queue and the emitter's registered current record before they
// can be popped. A byte yields at most two results and the output hands out
// one per cycle while pop is high, so results of frame-end bytes can back up
// in the four-entry event queue between the parser and the emitter. When pop
// stays low the current result holds and the queue fills; full rises once it
// has four pending records.
// Reset (rst, synchronous) returns the parser to the frame header and drops
// all pending results.
// ----------------------------------------------------------------------------
`default_nettype none

module ethercat_datagram_parser
  import edp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_end,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       payload_byte,
  output logic [10:0]      payload_offset,
  output logic [7:0]       command_code,
  output logic [7:0]       datagram_tag,
  output logic [31:0]      target_address,
  output logic [10:0]      payload_length,
  output logic [15:0]      working_counter,
  output logic [7:0]       datagram_total,
  output logic [1:0]       frame_status,
  output logic             run_last
);

  ev_t  wr_ev;
  ev_t  rd_ev;
  logic ev_wr;
  logic rd_valid;
  logic q_take;

  edp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (push && !full),
    .rx_byte   (rx_byte),
    .frame_end (frame_end),
    .ev_wr     (ev_wr),
    .ev        (wr_ev)
  );

  edp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (ev_wr),
    .wr_ev    (wr_ev),
    .wr_full  (full),
    .rd_en    (q_take),
    .rd_ev    (rd_ev),
    .rd_valid (rd_valid)
  );

  edp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_ev            (rd_ev),
    .q_valid         (rd_valid),
    .q_take          (q_take),
    .pop             (pop),
    .empty           (empty),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .payload_offset  (payload_offset),
    .command_code    (command_code),
    .datagram_tag    (datagram_tag),
    .target_address  (target_address),
    .payload_length  (payload_length),
    .working_counter (working_counter),
    .datagram_total  (datagram_total),
    .frame_status    (frame_status),
    .run_last        (run_last)
  );

endmodule

`default_nettype wire

FILE: rtl/edp_queue.sv
// ----------------------------------------------------------------------------
// edp_queue
// Short event queue between the byte parser and the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module edp_queue
  import edp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire ev_t  wr_ev,
  output logic      wr_full,
  input  wire logic rd_en,
  output ev_t       rd_ev,
  output logic      rd_valid
);

  ev_t                 mem [EV_DEPTH];
  logic [EV_PTR_W-1:0] wr_ptr;
  logic [EV_PTR_W-1:0] rd_ptr;
  logic [EV_CNT_W-1:0] count;

  assign wr_full  = (count == EV_CNT_W'(EV_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_ev    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/edp_front.sv
// ----------------------------------------------------------------------------
// edp_front
// Byte parser: walks frame header, datagram header, data and working counter,
// and emits one event record per byte that causes results.
// ----------------------------------------------------------------------------
`default_nettype none

module edp_front
  import edp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_end,
  output logic            ev_wr,
  output ev_t             ev
);

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] cnt, cnt_next;
  logic [7:0]       seen, seen_next;
  logic [7:0]       cmd, cmd_next;
  logic [7:0]       tag, tag_next;
  logic [31:0]      addr, addr_next;
  logic [LEN_W-1:0] len, len_next;
  logic             more, more_next;
  logic [7:0]       wlow, wlow_next;
  logic [LEN_W-1:0] cnt_inc;

  assign cnt_inc = cnt + 1'b1;

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    seen_next  = seen;
    cmd_next   = cmd;
    tag_next   = tag;
    addr_next  = addr;
    len_next   = len;
    more_next  = more;
    wlow_next  = wlow;
    unique case (phase)
      PH_FRAME: begin
        cnt_next = cnt_inc;
        if (cnt_inc >= LEN_W'(FRAME_HDR_BYTES)) begin
          phase_next = PH_HDR;
          cnt_next   = '0;
        end
      end
      PH_HDR: begin
        case (cnt)
          LEN_W'(0): cmd_next = rx_byte;
          LEN_W'(1): tag_next = rx_byte;
          LEN_W'(2): addr_next[7:0]   = rx_byte;
          LEN_W'(3): addr_next[15:8]  = rx_byte;
          LEN_W'(4): addr_next[23:16] = rx_byte;
          LEN_W'(5): addr_next[31:24] = rx_byte;
          LEN_W'(6): len_next[7:0] = rx_byte;
          LEN_W'(7): begin
            len_next[LEN_W-1:8] = rx_byte[LEN_W-9:0];
            more_next           = rx_byte[FOLLOW_BIT-8];
          end
          default: ;
        endcase
        cnt_next = cnt_inc;
        if (cnt_inc >= LEN_W'(DG_HDR_BYTES)) begin
          cnt_next   = '0;
          phase_next = (len != '0) ? PH_DATA : PH_WKC;
        end
      end
      PH_DATA: begin
        cnt_next = cnt_inc;
        if (cnt_inc >= len) begin
          cnt_next   = '0;
          phase_next = PH_WKC;
        end
      end
      PH_WKC: begin
        if (cnt == '0) begin
          wlow_next = rx_byte;
          cnt_next  = LEN_W'(1);
        end else begin
          if (seen != 8'hFF) begin
            seen_next = seen + 1'b1;
          end
          cnt_next   = '0;
          phase_next = more ? PH_HDR : PH_IGNORE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ev             = '0;
    ev.data_byte   = rx_byte;
    ev.data_offset = cnt;
    ev.cmd         = cmd;
    ev.tag         = tag;
    ev.addr        = addr;
    ev.len         = len;
    ev.wkc         = {rx_byte, wlow};
    ev.total       = seen_next;
    ev.has_end     = frame_end;
    unique case (phase)
      PH_DATA: ev.has_main = 1'b1;
      PH_WKC: begin
        ev.has_main   = (cnt != '0);
        ev.main_dgram = 1'b1;
      end
      default: ;
    endcase
    if (phase_next == PH_FRAME) begin
      ev.status = STAT_SHORT;
    end else if ((phase_next == PH_HDR && cnt_next != '0) ||
                 phase_next == PH_DATA || phase_next == PH_WKC) begin
      ev.status = STAT_UNFINISHED;
    end else begin
      ev.status = STAT_CLEAN;
    end
    ev_wr = accept && (ev.has_main || ev.has_end);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= cmd_next;
      tag  <= tag_next;
      addr <= addr_next;
      len  <= len_next;
      more <= more_next;
      wlow <= wlow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FRAME;
      cnt   <= '0;
      seen  <= '0;
    end else if (accept) begin
      if (frame_end) begin
        phase <= PH_FRAME;
        cnt   <= '0;
        seen  <= '0;
      end else begin
        phase <= phase_next;
        cnt   <= cnt_next;
        seen  <= seen_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/edp_back.sv
// ----------------------------------------------------------------------------
// edp_back
// Result emitter: holds one event record and hands out its results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module edp_back
  import edp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ev_t         q_ev,
  input  wire logic        q_valid,
  output logic             q_take,
  input  wire logic        pop,
  output logic             empty,
  output logic [1:0]       kind,
  output logic [7:0]       payload_byte,
  output logic [10:0]      payload_offset,
  output logic [7:0]       command_code,
  output logic [7:0]       datagram_tag,
  output logic [31:0]      target_address,
  output logic [10:0]      payload_length,
  output logic [15:0]      working_counter,
  output logic [7:0]       datagram_total,
  output logic [1:0]       frame_status,
  output logic             run_last
);

  ev_t  cur;
  logic cur_valid;
  logic on_end;
  logic advance;

  assign empty   = !cur_valid;
  assign advance = cur_valid && pop && (on_end || !cur.has_end);
  assign q_take  = q_valid && (!cur_valid || advance);

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      on_end    <= 1'b0;
    end else if (q_take) begin
      cur_valid <= 1'b1;
      on_end    <= !q_ev.has_main;
    end else if (advance) begin
      cur_valid <= 1'b0;
    end else if (cur_valid && pop) begin
      on_end <= 1'b1;
    end
  end

  always_comb begin
    kind            = KIND_DATA;
    payload_byte    = '0;
    payload_offset  = '0;
    command_code    = '0;
    datagram_tag    = '0;
    target_address  = '0;
    payload_length  = '0;
    working_counter = '0;
    datagram_total  = '0;
    frame_status    = STAT_CLEAN;
    run_last        = on_end || !cur.has_end;
    if (on_end) begin
      kind           = KIND_END;
      datagram_total = cur.total;
      frame_status   = cur.status;
    end else if (cur.main_dgram) begin
      kind            = KIND_DGRAM;
      command_code    = cur.cmd;
      datagram_tag    = cur.tag;
      target_address  = cur.addr;
      payload_length  = cur.len;
      working_counter = cur.wkc;
    end else begin
      payload_byte   = cur.data_byte;
      payload_offset = cur.data_offset;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/edp_checker.sv
// ----------------------------------------------------------------------------
// edp_checker
// Port-level checks of the EtherCAT datagram parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ethercat_datagram_parser_defines.svh"

module edp_checker
  import edp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  command_code,
  input wire logic [15:0] working_counter,
  input wire logic [7:0]  datagram_total,
  input wire logic [1:0]  frame_status,
  input wire logic        run_last
);

  `EDP_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> (empty && !full), "queues not drained after reset")
  `EDP_ASSERT(a_end_is_last, clk, rst, (!empty && kind == KIND_END) |-> run_last, "frame report not last")
  `EDP_ASSERT(a_data_clean, clk, rst, (!empty && kind == KIND_DATA) |-> (command_code == 8'd0 && working_counter == 16'd0 && datagram_total == 8'd0), "data result carries stray fields")
  `EDP_ASSERT(a_hold_on_stall, clk, rst, (!empty && !pop) |=> (!empty && $stable(kind) && $stable(frame_status)), "result changed while stalled")

endmodule

bind ethercat_datagram_parser edp_checker u_edp_checker (.*);

`default_nettype wire

FILE: test/tb_ethercat_datagram_parser.sv
// ----------------------------------------------------------------------------
// tb_ethercat_datagram_parser
// Self-checking bench for the EtherCAT datagram parser. A short table of
// directed bytes (short frames, extremes, ignored tail, cut datagram) runs
// first. Random frames follow: mostly well-formed datagram chains with random
// content, plus cut frames, tiny frames and noise, a datagram of several
// hundred bytes and a frame cut inside a datagram that declares the largest
// length. Each accepted byte is run through an in-bench parser model. Every
// popped record is compared in order against the model's output under four
// flow-control mixes on both ports.
// ----------------------------------------------------------------------------
module tb_ethercat_datagram_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import edp_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_BYTES = 250;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [10:0] payload_offset;
    logic [7:0]  command_code;
    logic [7:0]  datagram_tag;
    logic [31:0] target_address;
    logic [10:0] payload_length;
    logic [15:0] working_counter;
    logic [7:0]  datagram_total;
    logic [1:0]  frame_status;
    logic        run_last;
  } parse_record_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       last;
    logic       typed;
    logic [7:0] total;
    logic [1:0] status;
  } byte_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [10:0] payload_offset;
  logic [7:0]  command_code;
  logic [7:0]  datagram_tag;
  logic [31:0] target_address;
  logic [10:0] payload_length;
  logic [15:0] working_counter;
  logic [7:0]  datagram_total;
  logic [1:0]  frame_status;
  logic        run_last;

  ethercat_datagram_parser i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .frame_end       (frame_end),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .payload_offset  (payload_offset),
    .command_code    (command_code),
    .datagram_tag    (datagram_tag),
    .target_address  (target_address),
    .payload_length  (payload_length),
    .working_counter (working_counter),
    .datagram_total  (datagram_total),
    .frame_status    (frame_status),
    .run_last        (run_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  byte_row_t dir_rows [0:20] = '{
    '{8'h00, 1'b1, 1'b1, 8'd0, STAT_SHORT},
    '{8'h11, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'h22, 1'b1, 1'b1, 8'd0, STAT_CLEAN},
    '{8'h10, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'h00, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hFF, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'h00, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hFF, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hFF, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hFF, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hFF, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'h00, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'h78, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'h00, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hFF, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hFF, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hFF, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'h5A, 1'b1, 1'b1, 8'd1, STAT_CLEAN},
    '{8'hAB, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'hCD, 1'b0, 1'b0, 8'd0, STAT_CLEAN},
    '{8'h01, 1'b1, 1'b1, 8'd0, STAT_UNFINISHED}
  };

  parse_record_t owed_records [$];
  logic [7:0]    frame_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned bytes_fed = 0;
  int unsigned frames_fed = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned seen_data = 0;
  int unsigned seen_dgram = 0;
  int unsigned seen_end = 0;

  phase_t      ph;
  logic [10:0] step_cnt;
  logic [7:0]  cmd_q;
  logic [7:0]  tag_q;
  logic [31:0] addr_q;
  logic [10:0] len_q;
  logic        follow_q;
  logic [7:0]  wkc_lo_q;
  logic [7:0]  dgram_cnt;

  function automatic void clear_parse_state();
    ph        = PH_FRAME;
    step_cnt  = '0;
    cmd_q     = '0;
    tag_q     = '0;
    addr_q    = '0;
    len_q     = '0;
    follow_q  = 1'b0;
    wkc_lo_q  = '0;
    dgram_cnt = '0;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b, input logic last,
                                        input logic typed, input logic [7:0] tot,
                                        input logic [1:0] st);
    parse_record_t recs [0:1];
    int            n;
    int unsigned   i;
    logic [1:0]    status;
    n       = 0;
    recs[0] = '0;
    recs[1] = '0;
    case (ph)
      PH_FRAME: begin
        step_cnt = step_cnt + 1'b1;
        if (step_cnt >= FRAME_HDR_BYTES) begin
          ph       = PH_HDR;
          step_cnt = '0;
        end
      end
      PH_HDR: begin
        i = step_cnt;
        case (i)
          0: cmd_q = b;
          1: tag_q = b;
          2, 3, 4, 5: addr_q[8*(i-2) +: 8] = b;
          6: len_q[7:0] = b;
          7: begin
            len_q[10:8] = b[2:0];
            follow_q    = b[FOLLOW_BIT-8];
          end
          default: ;
        endcase
        step_cnt = step_cnt + 1'b1;
        if (step_cnt >= DG_HDR_BYTES) begin
          step_cnt = '0;
          ph       = (len_q != 0) ? PH_DATA : PH_WKC;
        end
      end
      PH_DATA: begin
        recs[n].kind           = KIND_DATA;
        recs[n].payload_byte   = b;
        recs[n].payload_offset = step_cnt;
        n++;
        step_cnt = step_cnt + 1'b1;
        if (step_cnt >= len_q) begin
          step_cnt = '0;
          ph       = PH_WKC;
        end
      end
      PH_WKC: begin
        if (step_cnt == 0) begin
          wkc_lo_q = b;
          step_cnt = 11'd1;
        end else begin
          recs[n].kind            = KIND_DGRAM;
          recs[n].command_code    = cmd_q;
          recs[n].datagram_tag    = tag_q;
          recs[n].target_address  = addr_q;
          recs[n].payload_length  = len_q;
          recs[n].working_counter = {b, wkc_lo_q};
          n++;
          if (dgram_cnt != 8'hFF) dgram_cnt = dgram_cnt + 1'b1;
          step_cnt = '0;
          ph       = follow_q ? PH_HDR : PH_IGNORE;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (ph == PH_FRAME) status = STAT_SHORT;
      else if ((ph == PH_HDR && step_cnt != 0) || ph == PH_DATA || ph == PH_WKC)
        status = STAT_UNFINISHED;
      else status = STAT_CLEAN;
      recs[n].kind           = KIND_END;
      recs[n].datagram_total = typed ? tot : dgram_cnt;
      recs[n].frame_status   = typed ? st : status;
      n++;
      clear_parse_state();
    end
    if (n > 0) recs[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) owed_records.insert(owed_records.size(), recs[k]);
  endfunction

  function automatic string show_record(input parse_record_t r);
    return $sformatf({"kind %0d byte %h off %0d cmd %h tag %h addr %h len %0d",
                      " wkc %h total %0d status %0d last %0d"},
                     r.kind, r.payload_byte, r.payload_offset, r.command_code,
                     r.datagram_tag, r.target_address, r.payload_length,
                     r.working_counter, r.datagram_total, r.frame_status, r.run_last);
  endfunction

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    parse_record_t got;
    parse_record_t want;
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d records still owed",
                 quiet_cycles, owed_records.size());
        $display("Verification failed");
        $finish;
      end
      if (pop && !empty) begin
        got = '{kind, payload_byte, payload_offset, command_code, datagram_tag,
                target_address, payload_length, working_counter, datagram_total,
                frame_status, run_last};
        case (got.kind)
          KIND_DATA:  seen_data++;
          KIND_DGRAM: seen_dgram++;
          default:    seen_end++;
        endcase
        if (owed_records.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t unexpected record: %s", $realtime, show_record(got));
        end else begin
          want = owed_records.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
              $display("%0t mismatch expected: %s", $realtime, show_record(want));
              $display("%0t mismatch actual:   %s", $realtime, show_record(got));
            end
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic [7:0] tot, input logic [1:0] st);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    rx_byte   <= b;
    frame_end <= last;
    while (!taken) begin
      @(posedge clk);
      if (!full) begin
        taken = 1'b1;
        bytes_fed++;
        parse_rx_byte(b, last, typed, tot, st);
      end
      @(negedge clk);
    end
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_q.size(); k++)
      send_byte(frame_q[k], k == frame_q.size() - 1, 1'b0, 8'd0, STAT_CLEAN);
    frames_fed++;
    frame_q.delete();
  endtask

  function automatic void append_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void add_datagram(input logic [10:0] len, input logic follow);
    logic [31:0] a;
    logic [3:0]  junk;
    a    = $urandom;
    junk = 4'($urandom_range(15));
    append_byte(8'($urandom_range(255)));
    append_byte(8'($urandom_range(255)));
    for (int k = 0; k < 4; k++) append_byte(a[8*k +: 8]);
    append_byte(len[7:0]);
    append_byte({follow, junk, len[10:8]});
    repeat (2) append_byte(8'($urandom_range(255)));
    repeat (len) append_byte(8'($urandom_range(255)));
    repeat (2) append_byte(8'($urandom_range(255)));
  endfunction

  function automatic void build_random_frame();
    int unsigned pick;
    int unsigned ndg;
    int unsigned cut;
    logic [10:0] len;
    logic        follow;
    pick   = $urandom_range(99);
    follow = 1'b0;
    frame_q.delete();
    if (pick < 8) begin
      repeat ($urandom_range(1, 2)) append_byte(8'($urandom_range(255)));
    end else if (pick < 16) begin
      repeat ($urandom_range(1, 30)) append_byte(8'($urandom_range(255)));
    end else begin
      repeat (2) append_byte(8'($urandom_range(255)));
      ndg = $urandom_range(1, 4);
      for (int d = 0; d < ndg; d++) begin
        len    = ($urandom_range(99) < 80) ? 11'($urandom_range(0, 6))
                                           : 11'($urandom_range(7, 40));
        follow = (d < ndg - 1) || ($urandom_range(9) == 0);
        add_datagram(len, follow);
      end
      if (!follow) repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(255)));
      if (pick < 32) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endfunction

  initial begin
    int unsigned start;
    clear_parse_state();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r])
      send_byte(dir_rows[r].rx, dir_rows[r].last, dir_rows[r].typed,
                dir_rows[r].total, dir_rows[r].status);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 68; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 68; end
        default: begin send_idle_pct = 13; pop_stall_pct = 13; end
      endcase
      if (p == 1) begin
        repeat (2) append_byte(8'($urandom_range(255)));
        add_datagram(11'($urandom_range(256, 300)), 1'b0);
        send_frame();
      end else if (p == 2) begin
        repeat (2) append_byte(8'($urandom_range(255)));
        add_datagram(11'd2047, 1'b0);
        while (frame_q.size() > 42) void'(frame_q.pop_back());
        send_frame();
      end
      start = bytes_fed;
      while (bytes_fed - start < PHASE_BYTES) begin
        build_random_frame();
        send_frame();
      end
      push <= 1'b0;
      while (owed_records.size() != 0) @(negedge clk);
      @(negedge clk);
    end

    repeat (16) @(negedge clk);
    $display("Fed %0d bytes in %0d frames; checked %0d data, %0d datagram, %0d frame-end records",
             bytes_fed, frames_fed, seen_data, seen_dgram, seen_end);
    $display({"Covered short, cut and noisy frames, ignored tails, long datagrams",
              " and the largest declared length under four flow-control mixes"});
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatching records", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
